### rtl/qck_pkg.sv
// Package for the quadtree cell key block: default sizes, controller state type
// and the command/status words between controller and datapath.
// No dependencies.
`default_nettype none

package qck_pkg;

    // Default coordinate format: signed fixed point
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Width of the cell level result
    localparam int LEVEL_BITS = 6;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SPAN,
        ST_SEARCH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;   // capture and order the incoming bounds
        logic init;   // form the extent, reset the level search
        logic step;   // move one level up
        logic emit;   // copy the current cell into the result registers
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic done;   // box fits at this level, or the top level is reached
    } sts_t;

endpackage

`default_nettype wire

### rtl/qck_ctrl.sv
// Controller of the quadtree cell key block: sequences load, extent, level search
// and result hand-off. Uses qck_pkg.
`default_nettype none

module qck_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          box_valid,
    output logic               box_stall,
    output logic               cell_valid,
    input  wire logic          cell_stall,
    input  wire qck_pkg::sts_t sts,
    output qck_pkg::cmd_t      cmd
);
    import qck_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   cell_valid_reg;
    logic   cell_valid_next;
    logic   out_free;

    // Result register can take a new word
    assign out_free = !cell_valid_reg || !cell_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (box_valid)
                begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:
            begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (sts.done && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        box_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                box_stall = 1'b0;
                cmd.load  = box_valid;
            end
            ST_SPAN:
            begin
                cmd.init = 1'b1;
            end
            ST_SEARCH:
            begin
                cmd.step = !sts.done;
                cmd.emit = sts.done && out_free;
            end
            default:
            begin
                box_stall = 1'b1;
            end
        endcase
    end

    // Result valid flag
    always_comb
    begin
        cell_valid_next = cell_valid_reg;
        if (cmd.emit)
        begin
            cell_valid_next = 1'b1;
        end
        else if (!cell_stall)
        begin
            cell_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cell_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cell_valid_reg <= cell_valid_next;
        end
    end

    assign cell_valid = cell_valid_reg;

endmodule

`default_nettype wire

### rtl/qck_datapath.sv
// Datapath of the quadtree cell key block: bound ordering, extent, level search
// registers, containment test and result registers. Uses qck_pkg.
`default_nettype none

module qck_datapath #(
    parameter int COORD_BITS = qck_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = qck_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire qck_pkg::cmd_t                       cmd,
    output qck_pkg::sts_t                            sts,
    input  wire logic signed [COORD_BITS-1:0]        min_x,
    input  wire logic signed [COORD_BITS-1:0]        max_x,
    input  wire logic signed [COORD_BITS-1:0]        min_y,
    input  wire logic signed [COORD_BITS-1:0]        max_y,
    output logic signed [qck_pkg::LEVEL_BITS-1:0]    cell_level,
    output logic signed [COORD_BITS:0]               corner_x,
    output logic signed [COORD_BITS:0]               corner_y,
    output logic                                     fits
);
    import qck_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int SW = $clog2(COORD_BITS + 1);

    // Ordered bounds
    logic signed [C-1:0] lx_reg, hx_reg, ly_reg, hy_reg;
    // Extent shifted right once per level; zero once the level covers it
    logic [C-1:0]        ext_sh_reg;
    // Level search: shift, corner mask, cell side
    logic [SW-1:0]       s_reg;
    logic [C:0]          mask_reg;
    logic [C+1:0]        side_reg;
    // Result registers
    logic signed [LEVEL_BITS-1:0] level_reg;
    logic signed [C:0]   cx_out_reg, cy_out_reg;
    logic                fits_reg;

    logic [C-1:0]        dx, dy, ext;
    logic signed [C:0]   cx, cy;
    logic signed [C+1:0] lim_x, lim_y;
    logic                fit_x, fit_y, covered, fit_now, top;

    // Extent of the ordered box; difference is below 2^C so it wraps safely
    assign dx  = hx_reg - lx_reg;
    assign dy  = hy_reg - ly_reg;
    assign ext = (dy > dx) ? dy : dx;

    // Floored corners and closed containment test at the current level
    assign cx      = {lx_reg[C-1], lx_reg} & mask_reg;
    assign cy      = {ly_reg[C-1], ly_reg} & mask_reg;
    assign lim_x   = {cx[C], cx} + $signed(side_reg);
    assign lim_y   = {cy[C], cy} + $signed(side_reg);
    assign fit_x   = $signed({{2{hx_reg[C-1]}}, hx_reg}) <= lim_x;
    assign fit_y   = $signed({{2{hy_reg[C-1]}}, hy_reg}) <= lim_y;
    assign covered = (ext_sh_reg == '0);
    assign fit_now = covered && fit_x && fit_y;
    assign top     = (s_reg == SW'(COORD_BITS));

    assign sts.done = fit_now || top;

    // Bounds, swapped when given in reverse
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lx_reg <= (max_x < min_x) ? max_x : min_x;
            hx_reg <= (max_x < min_x) ? min_x : max_x;
            ly_reg <= (max_y < min_y) ? max_y : min_y;
            hy_reg <= (max_y < min_y) ? min_y : max_y;
        end
    end

    // Level search registers
    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            ext_sh_reg <= ext;
            s_reg      <= '0;
            mask_reg   <= '1;
            side_reg   <= (C+2)'(1);
        end
        else if (cmd.step)
        begin
            ext_sh_reg <= ext_sh_reg >> 1;
            s_reg      <= s_reg + SW'(1);
            mask_reg   <= mask_reg << 1;
            side_reg   <= side_reg << 1;
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            level_reg  <= LEVEL_BITS'(int'(s_reg) - FRAC_BITS);
            cx_out_reg <= cx;
            cy_out_reg <= cy;
            fits_reg   <= fit_now;
        end
    end

    assign cell_level = level_reg;
    assign corner_x   = cx_out_reg;
    assign corner_y   = cy_out_reg;
    assign fits       = fits_reg;

endmodule

`default_nettype wire

### rtl/quadtree_cell_key.sv
// Quadtree cell key: smallest aligned power-of-two square cell that holds a box.
// The box is captured and ordered, its extent is formed, then the level search runs;
// the level search tests one level per cycle, starting at the lowest level.
// A new box is taken only once the last one is in the result register; a waiting
// result word does not block the next input word. Depends on qck_pkg, qck_ctrl, qck_datapath.
// Reset: async, active low; clears the controller and the result valid.
`default_nettype none

module quadtree_cell_key #(
    parameter int COORD_BITS = qck_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = qck_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              box_valid,
    output logic                                   box_stall,
    input  wire logic signed [COORD_BITS-1:0]      min_x,
    input  wire logic signed [COORD_BITS-1:0]      max_x,
    input  wire logic signed [COORD_BITS-1:0]      min_y,
    input  wire logic signed [COORD_BITS-1:0]      max_y,
    output logic                                   cell_valid,
    input  wire logic                              cell_stall,
    output logic signed [qck_pkg::LEVEL_BITS-1:0]  cell_level,
    output logic signed [COORD_BITS:0]             corner_x,
    output logic signed [COORD_BITS:0]             corner_y,
    output logic                                   fits
);
    import qck_pkg::*;

    cmd_t cmd;
    sts_t sts;

    qck_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .box_valid  (box_valid),
        .box_stall  (box_stall),
        .cell_valid (cell_valid),
        .cell_stall (cell_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    qck_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .sts        (sts),
        .min_x      (min_x),
        .max_x      (max_x),
        .min_y      (min_y),
        .max_y      (max_y),
        .cell_level (cell_level),
        .corner_x   (corner_x),
        .corner_y   (corner_y),
        .fits       (fits)
    );

endmodule

`default_nettype wire

### rtl/qck_checker.sv
// Port-level checks for the quadtree cell key block, bound to the top level.
// Uses qck_pkg for the level width.
`default_nettype none

module qck_checker #(
    parameter int COORD_BITS = qck_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = qck_pkg::FRAC_BITS_DEF
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              box_valid,
    input wire logic                              box_stall,
    input wire logic                              cell_valid,
    input wire logic                              cell_stall,
    input wire logic signed [qck_pkg::LEVEL_BITS-1:0] cell_level,
    input wire logic signed [COORD_BITS:0]        corner_x,
    input wire logic signed [COORD_BITS:0]        corner_y,
    input wire logic                              fits
);
    import qck_pkg::*;

    localparam logic signed [LEVEL_BITS-1:0] TOP_LEVEL =
        LEVEL_BITS'(COORD_BITS - FRAC_BITS);

    // Low corner bits that the current level must have cleared
    logic [COORD_BITS:0] low_mask;
    int                  shift;

    assign shift    = int'(cell_level) + FRAC_BITS;
    assign low_mask = ~((~(COORD_BITS+1)'(0)) << shift);

    // A held result word does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && cell_stall |=> cell_valid && $stable(cell_level)
            && $stable(corner_x) && $stable(corner_y) && $stable(fits))
        else $error("result word changed while stalled");

    // The block is busy right after taking a box
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !box_stall |=> box_stall)
        else $error("second box taken while first in work");

    // A failed search ends at the top level
    a_top: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid && !fits |-> cell_level == TOP_LEVEL)
        else $error("fit failure below top level");

    // Corners are aligned to the cell side
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid |-> ((corner_x & low_mask) == '0) && ((corner_y & low_mask) == '0))
        else $error("corner not aligned to cell side");

endmodule

bind quadtree_cell_key qck_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_qck_checker (.*);

`default_nettype wire
